[rtl/rational_arith_unit_assert.svh]
// Assertion macros for the rational arithmetic unit.
// Used by rational_arith_unit.sv; expects clk and rst_n in scope.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational_arith_unit: assertion failed");

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational_arith_unit: assertion failed");

`endif

[rtl/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic               status;
    } rsp_t;

    // classified item between front and back
    typedef struct packed {
        op_t                op;
        logic               err;
        logic signed [31:0] an;
        logic signed [31:0] ad;
        logic signed [31:0] bn;
        logic signed [31:0] bd;
    } cls_t;

endpackage

[rtl/rational_arith_unit.sv]
// Rational arithmetic unit: one reduced fraction per request word.
// Error words skip to the output; a zero result ends after the products and
// combine step; others also run the binary GCD and the divisions. The back
// end takes a new word only once through with the last; a 2-entry queue
// keeps accepting meanwhile. Reset: async, active low, clears queue and
// controller; no clearing pass.
// Depends on rau_pkg, rau_front, rau_back, rational_arith_unit_assert.svh.
module rational_arith_unit #(
    parameter int OPW = rau_pkg::OPERAND_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rau_pkg::req_t req_word,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rau_pkg::rsp_t rsp_word
);
    import rau_pkg::*;

    `include "rational_arith_unit_assert.svh"

    logic cls_valid, cls_pop;
    cls_t cls_word;

    rau_front #(.OPW(OPW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .cls_valid (cls_valid),
        .cls_pop   (cls_pop),
        .cls_word  (cls_word)
    );

    rau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (cls_valid),
        .cls_pop   (cls_pop),
        .cls_word  (cls_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    `RAU_ASSERT_IMP(a_ok_den_nz, rsp_valid && !rsp_word.status, rsp_word.res_den != '0)
    `RAU_ASSERT_IMP(a_err_zero, rsp_valid && rsp_word.status, rsp_word.res_num == '0 && rsp_word.res_den == '0)
    `RAU_ASSERT_IMP(a_zero_canon, rsp_valid && !rsp_word.status && rsp_word.res_num == '0, rsp_word.res_den == 63'd1)
    `RAU_ASSERT_NXT(a_stall_full, req_valid && req_stall && !cls_pop, req_stall)

endmodule

[rtl/rau_front.sv]
// Front end: accepts request words, normalizes operands, flags errors,
// and buffers classified items in a short queue. Depends on rau_pkg.
module rau_front #(
    parameter int OPW = rau_pkg::OPERAND_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rau_pkg::req_t req_word,
    output logic          cls_valid,
    input  logic          cls_pop,
    output rau_pkg::cls_t cls_word
);
    import rau_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cls_t          q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    cls_t          cls_in;
    logic          push, pop;

    // low OPW bits as two's complement, most negative value saturated
    function automatic logic signed [31:0] read_op(input logic [31:0] raw);
        logic [OPW-1:0]     v;
        logic signed [31:0] s;
        v = raw[OPW-1:0];
        s = 32'($signed(v));
        if (v == {1'b1, {(OPW-1){1'b0}}})
            s = s + 32'sd1;
        return s;
    endfunction

    always_comb
    begin
        cls_in.op  = op_t'(req_word.cmd);
        cls_in.an  = read_op(req_word.a_num);
        cls_in.ad  = read_op(req_word.a_den);
        cls_in.bn  = read_op(req_word.b_num);
        cls_in.bd  = read_op(req_word.b_den);
        cls_in.err = (cls_in.ad == '0) || (cls_in.bd == '0) ||
                     ((cls_in.op == OP_DIV) && (cls_in.bn == '0));
    end

    assign req_stall = (cnt_reg == CW'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign cls_valid = (cnt_reg != '0);
    assign pop       = cls_pop && cls_valid;
    assign cls_word  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = CW'(cnt_reg + 1'b1);
        else if (pop && !push)
            cnt_next = CW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls_in;
    end

endmodule

[rtl/rau_back.sv]
// Back end: products on one shared multiplier, binary GCD, and two
// bit-serial divisions for the reduction; holds the output register.
// Depends on rau_pkg.
module rau_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cls_valid,
    output logic          cls_pop,
    input  rau_pkg::cls_t cls_word,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rau_pkg::rsp_t rsp_word
);
    import rau_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_COMB, S_GCD, S_DIV, S_DONE
    } state_t;

    state_t             st_reg, st_next;
    cls_t               item_reg, item_next;
    logic [1:0]         step_reg, step_next;
    logic signed [63:0] t0_reg, t0_next, t1_reg, t1_next, den_reg, den_next;
    logic               neg_reg, neg_next;
    logic [63:0]        u_reg, u_next, v_reg, v_next;
    logic [5:0]         k_reg, k_next;
    logic [63:0]        g_reg, g_next;
    logic [63:0]        mn_reg, mn_next, md_reg, md_next;
    logic [63:0]        rn_reg, rn_next, rd_reg, rd_next;
    logic [63:0]        qn_reg, qn_next, qd_reg, qd_next;
    logic [5:0]         cnt_reg, cnt_next;
    rsp_t               res_reg, res_next;
    rsp_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [31:0] mx, my;
    logic signed [63:0] prod, num;
    logic [64:0]        rn_t, rd_t;
    logic               bn_q, bd_q;
    logic [63:0]        qn_t, qd_t;

    assign cls_pop   = (st_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

    // one 32x32 product per step
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mx = item_reg.an;
                my = (item_reg.op == OP_MUL) ? item_reg.bn : item_reg.bd;
            end
            2'd1:
            begin
                mx = item_reg.bn;
                my = item_reg.ad;
            end
            default:
            begin
                mx = item_reg.ad;
                my = (item_reg.op == OP_DIV) ? item_reg.bn : item_reg.bd;
            end
        endcase
        prod = 64'(mx) * 64'(my);
    end

    always_comb
    begin
        case (item_reg.op)
            OP_ADD:  num = t0_reg + t1_reg;
            OP_SUB:  num = t0_reg - t1_reg;
            default: num = t0_reg;
        endcase
    end

    // restoring division step for both quotients
    always_comb
    begin
        rn_t = {rn_reg, mn_reg[63]};
        rd_t = {rd_reg, md_reg[63]};
        bn_q = (rn_t >= {1'b0, g_reg});
        bd_q = (rd_t >= {1'b0, g_reg});
        qn_t = {qn_reg[62:0], bn_q};
        qd_t = {qd_reg[62:0], bd_q};
    end

    always_comb
    begin
        st_next        = st_reg;
        item_next      = item_reg;
        step_next      = step_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        mn_next        = mn_reg;
        md_next        = md_reg;
        rn_next        = rn_reg;
        rd_next        = rd_reg;
        qn_next        = qn_reg;
        qd_next        = qd_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;

        case (st_reg)
            S_IDLE:
            begin
                if (cls_valid)
                begin
                    item_next = cls_word;
                    step_next = 2'd0;
                    if (cls_word.err)
                    begin
                        res_next = '{res_num: '0, res_den: '0, status: 1'b1};
                        st_next  = S_DONE;
                    end
                    else
                        st_next = S_MUL;
                end
            end
            S_MUL:
            begin
                case (step_reg)
                    2'd0:    t0_next  = prod;
                    2'd1:    t1_next  = prod;
                    default: den_next = prod;
                endcase
                step_next = 2'(step_reg + 1'b1);
                if (step_reg == 2'd2)
                    st_next = S_COMB;
            end
            S_COMB:
            begin
                if (num == '0)
                begin
                    res_next = '{res_num: '0, res_den: 63'd1, status: 1'b0};
                    st_next  = S_DONE;
                end
                else
                begin
                    neg_next = num[63] ^ den_reg[63];
                    mn_next  = num[63] ? 64'(-num) : 64'(num);
                    md_next  = den_reg[63] ? 64'(-den_reg) : 64'(den_reg);
                    u_next   = mn_next;
                    v_next   = md_next;
                    k_next   = '0;
                    st_next  = S_GCD;
                end
            end
            S_GCD:
            begin
                if (u_reg == v_reg)
                begin
                    g_next   = u_reg << k_reg;
                    rn_next  = '0;
                    rd_next  = '0;
                    cnt_next = '0;
                    st_next  = S_DIV;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = 6'(k_reg + 1'b1);
                end
                else if (!u_reg[0])
                    u_next = u_reg >> 1;
                else if (!v_reg[0])
                    v_next = v_reg >> 1;
                else if (u_reg > v_reg)
                    u_next = (u_reg - v_reg) >> 1;
                else
                    v_next = (v_reg - u_reg) >> 1;
            end
            S_DIV:
            begin
                rn_next  = bn_q ? 64'(rn_t - {1'b0, g_reg}) : rn_t[63:0];
                rd_next  = bd_q ? 64'(rd_t - {1'b0, g_reg}) : rd_t[63:0];
                mn_next  = mn_reg << 1;
                md_next  = md_reg << 1;
                qn_next  = qn_t;
                qd_next  = qd_t;
                cnt_next = 6'(cnt_reg + 1'b1);
                if (cnt_reg == 6'd63)
                begin
                    res_next.res_num = neg_reg ? -$signed(qn_t) : $signed(qn_t);
                    res_next.res_den = qd_t[62:0];
                    res_next.status  = 1'b0;
                    st_next          = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    st_next        = S_IDLE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        step_reg <= step_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        k_reg    <= k_next;
        g_reg    <= g_next;
        mn_reg   <= mn_next;
        md_reg   <= md_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        qn_reg   <= qn_next;
        qd_reg   <= qd_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule
